// ===== src/wrmsd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wrmsd_pkg: shared types and constants of the weighted RMSD accumulator
// Word formats of both channels, controller states, and the command and
// status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package wrmsd_pkg;

  // Field and accumulator widths
  localparam int unsigned MASS_W     = 16;
  localparam int unsigned COORD_W    = 24;
  localparam int unsigned MASS_ACC_W = 48;
  localparam int unsigned SUM_W      = 64;
  localparam int unsigned DEV_W      = 32;
  localparam int unsigned MAG_W      = COORD_W + 1;   // |a +/- b| <= 2^24
  localparam int unsigned SQ_W       = 2 * COORD_W + 1; // square <= 2^48

  // Rho mode scales the ratio by 2^34 so that sqrt gives 2*sqrt(ratio) in Q16.16
  localparam int unsigned RHO_SHIFT  = 34;
  localparam int unsigned SAT_SHIFT  = 30;
  localparam int unsigned DIV_CNT_W  = 7;

  // Coordinate index: x, y, z
  localparam int unsigned DIMENSIONS_DEF = 3;
  localparam int unsigned DIM_W          = 2;
  localparam logic [DIM_W-1:0] DIM_X = 2'd0;
  localparam logic [DIM_W-1:0] DIM_Y = 2'd1;

  typedef struct packed {
    logic        [MASS_W-1:0]  mass;
    logic signed [COORD_W-1:0] cur_x;
    logic signed [COORD_W-1:0] cur_y;
    logic signed [COORD_W-1:0] cur_z;
    logic signed [COORD_W-1:0] ref_x;
    logic signed [COORD_W-1:0] ref_y;
    logic signed [COORD_W-1:0] ref_z;
    logic                      last_atom;
  } in_word_t;

  typedef struct packed {
    logic [DEV_W-1:0] deviation;
    logic             zero_denominator;
    logic             saturated;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQR,
    ST_MUL,
    ST_ACC,
    ST_CHECK,
    ST_DIV,
    ST_SQRT,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic             load;
    logic             square;
    logic             scale;
    logic             accum;
    logic             check;
    logic             div_step;
    logic             sqrt_step;
    logic             emit;
    logic [DIM_W-1:0] dim;
  } cmd_t;

  typedef struct packed {
    logic last_atom;
    logic special;
    logic div_last;
    logic sqrt_last;
    logic out_free;
  } stat_t;

endpackage
`default_nettype wire

// ===== src/wrmsd_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wrmsd_dp: datapath of the weighted RMSD accumulator
// Input register, square and mass multipliers, saturating sums, a radix-2
// restoring divider and a bit-serial square root, and the output register.
// ----------------------------------------------------------------------------
module wrmsd_dp (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     cfg_we_i,
  input  wire                     cfg_wdata_i,
  input  wrmsd_pkg::in_word_t     in_word_i,
  input  wire                     out_ready_i,
  output logic                    out_valid_o,
  output wrmsd_pkg::out_word_t    out_word_o,
  input  wrmsd_pkg::cmd_t         cmd_i,
  output wrmsd_pkg::stat_t        stat_o
);

  localparam int unsigned SumW  = wrmsd_pkg::SUM_W;
  localparam int unsigned MAccW = wrmsd_pkg::MASS_ACC_W;
  localparam int unsigned MagW  = wrmsd_pkg::MAG_W;
  localparam int unsigned SqW   = wrmsd_pkg::SQ_W;
  localparam int unsigned CntW  = wrmsd_pkg::DIV_CNT_W;
  localparam int unsigned DevW  = wrmsd_pkg::DEV_W;
  localparam int unsigned ShW   = wrmsd_pkg::SAT_SHIFT;
  localparam int unsigned CW    = wrmsd_pkg::COORD_W;

  // Configuration register
  logic rho_q;

  // Atom register and pipeline registers
  wrmsd_pkg::in_word_t in_q;
  logic [SqW-1:0]  sq_diff_q, sq_sum_q;
  logic [SumW-1:0] term_diff_q, term_sum_q;

  // Accumulators
  logic [MAccW-1:0] mass_tot_q;
  logic [SumW-1:0]  diff_acc_q, sum_acc_q;
  logic             ovf_q;

  // Divider and square root
  logic [SumW-1:0] rem_q, num_q, den_q, quo_q, root_q, bit_q;
  logic [CntW-1:0] cnt_q;

  // Result and output register
  logic [DevW-1:0]      dev_q;
  logic                 zero_q;
  logic                 out_valid_q;
  wrmsd_pkg::out_word_t out_q;

  // Coordinate select for the current dimension
  logic signed [CW-1:0] cur_sel, ref_sel;
  always_comb begin
    unique case (cmd_i.dim)
      wrmsd_pkg::DIM_X: begin
        cur_sel = in_q.cur_x;
        ref_sel = in_q.ref_x;
      end
      wrmsd_pkg::DIM_Y: begin
        cur_sel = in_q.cur_y;
        ref_sel = in_q.ref_y;
      end
      default: begin
        cur_sel = in_q.cur_z;
        ref_sel = in_q.ref_z;
      end
    endcase
  end

  // Difference, sum and their magnitudes
  logic [MagW-1:0] dval, sval, dmag, smag;
  logic [2*MagW-1:0] dsq_full, ssq_full;
  always_comb begin
    dval     = {cur_sel[CW-1], cur_sel} - {ref_sel[CW-1], ref_sel};
    sval     = {cur_sel[CW-1], cur_sel} + {ref_sel[CW-1], ref_sel};
    dmag     = dval[MagW-1] ? (~dval + MagW'(1)) : dval;
    smag     = sval[MagW-1] ? (~sval + MagW'(1)) : sval;
    dsq_full = dmag * dmag;
    ssq_full = smag * smag;
  end

  // Mass scaling: the product stays below 2^64
  logic [SqW+wrmsd_pkg::MASS_W-1:0] tdiff_full, tsum_full;
  always_comb begin
    tdiff_full = sq_diff_q * in_q.mass;
    tsum_full  = sq_sum_q * in_q.mass;
  end

  // Saturating adds
  logic [MAccW:0] mass_add;
  logic [SumW:0]  diff_add, sum_add;
  always_comb begin
    mass_add = {1'b0, mass_tot_q} + (MAccW+1)'(in_word_i.mass);
    diff_add = {1'b0, diff_acc_q} + {1'b0, term_diff_q};
    sum_add  = {1'b0, sum_acc_q} + {1'b0, term_sum_q};
  end

  // Special cases at the end of a set
  logic zero_den, too_big;
  always_comb begin
    zero_den = rho_q ? (sum_acc_q == '0) : (mass_tot_q == '0);
    too_big  = rho_q && (sum_acc_q != '0) &&
               ({{ShW{1'b0}}, diff_acc_q} >= {sum_acc_q, {ShW{1'b0}}});
  end

  // Divider step
  logic [SumW:0]   div_shift, div_diff;
  logic            div_bit;
  always_comb begin
    div_shift = {rem_q, num_q[SumW-1]};
    div_diff  = div_shift - {1'b0, den_q};
    div_bit   = !div_diff[SumW];
  end

  // Square root step
  logic [SumW-1:0] sq_trial, root_d;
  logic            sq_take;
  always_comb begin
    sq_trial = root_q + bit_q;
    sq_take  = quo_q >= sq_trial;
    root_d   = sq_take ? ((root_q >> 1) + bit_q) : (root_q >> 1);
  end

  // Hold the configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rho_q <= 1'b0;
    end else if (cfg_we_i) begin
      rho_q <= cfg_wdata_i;
    end
  end

  // Capture the atom, square, then scale by mass
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      in_q <= in_word_i;
    end
    if (cmd_i.square) begin
      sq_diff_q <= dsq_full[SqW-1:0];
      sq_sum_q  <= ssq_full[SqW-1:0];
    end
    if (cmd_i.scale) begin
      term_diff_q <= tdiff_full[SumW-1:0];
      term_sum_q  <= tsum_full[SumW-1:0];
    end
  end

  // Accumulate with saturation; clear when the result leaves
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mass_tot_q <= '0;
      diff_acc_q <= '0;
      sum_acc_q  <= '0;
      ovf_q      <= 1'b0;
    end else if (cmd_i.emit) begin
      mass_tot_q <= '0;
      diff_acc_q <= '0;
      sum_acc_q  <= '0;
      ovf_q      <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        mass_tot_q <= mass_add[MAccW] ? '1 : mass_add[MAccW-1:0];
        if (mass_add[MAccW]) begin
          ovf_q <= 1'b1;
        end
      end
      if (cmd_i.accum) begin
        diff_acc_q <= diff_add[SumW] ? '1 : diff_add[SumW-1:0];
        if (rho_q) begin
          sum_acc_q <= sum_add[SumW] ? '1 : sum_add[SumW-1:0];
        end
        if (diff_add[SumW] || (rho_q && sum_add[SumW])) begin
          ovf_q <= 1'b1;
        end
      end
    end
  end

  // Divide, then take the root of the quotient in place
  always_ff @(posedge clk_i) begin
    if (cmd_i.check) begin
      dev_q  <= too_big ? '1 : '0;
      zero_q <= zero_den;
      rem_q  <= '0;
      num_q  <= diff_acc_q;
      den_q  <= rho_q ? sum_acc_q : SumW'(mass_tot_q);
      quo_q  <= '0;
      cnt_q  <= rho_q ? CntW'(SumW + wrmsd_pkg::RHO_SHIFT - 1) : CntW'(SumW - 1);
      root_q <= '0;
      bit_q  <= SumW'(1) << (SumW - 2);
    end else if (cmd_i.div_step) begin
      rem_q <= div_bit ? div_diff[SumW-1:0] : div_shift[SumW-1:0];
      num_q <= num_q << 1;
      quo_q <= {quo_q[SumW-2:0], div_bit};
      cnt_q <= cnt_q - CntW'(1);
    end else if (cmd_i.sqrt_step) begin
      if (sq_take) begin
        quo_q <= quo_q - sq_trial;
      end
      root_q <= root_d;
      bit_q  <= bit_q >> 2;
      if (bit_q[0]) begin
        dev_q <= root_d[DevW-1:0];
      end
    end
  end

  // Output register: load on emit, drop once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q.deviation        <= dev_q;
      out_q.zero_denominator <= zero_q;
      out_q.saturated        <= ovf_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // Status toward the controller
  always_comb begin
    stat_o.last_atom = in_q.last_atom;
    stat_o.special   = zero_den || too_big;
    stat_o.div_last  = (cnt_q == '0);
    stat_o.sqrt_last = bit_q[0];
    stat_o.out_free  = !out_valid_q || out_ready_i;
  end

endmodule
`default_nettype wire

// ===== src/wrmsd_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wrmsd_ctrl: sequencer of the weighted RMSD accumulator
// Steps each atom through square, scale and accumulate per dimension, and
// on the last atom through check, divide and square root (both skipped on a special case) and result hand-off.
// ----------------------------------------------------------------------------
module wrmsd_ctrl #(
  parameter int unsigned DIMENSIONS = wrmsd_pkg::DIMENSIONS_DEF
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_ready_o,
  output wrmsd_pkg::cmd_t    cmd_o,
  input  wrmsd_pkg::stat_t   stat_i
);

  localparam int unsigned DimW = wrmsd_pkg::DIM_W;
  localparam logic [DimW-1:0] DimLast = DimW'(DIMENSIONS - 1);

  wrmsd_pkg::state_e state_q, state_d;
  logic [DimW-1:0]   dim_q, dim_d;
  logic              dim_last;

  assign dim_last = (dim_q == DimLast);

  // Next state and dimension index
  always_comb begin
    state_d = state_q;
    dim_d   = dim_q;
    unique case (state_q)
      wrmsd_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = wrmsd_pkg::ST_SQR;
          dim_d   = '0;
        end
      end
      wrmsd_pkg::ST_SQR: begin
        state_d = wrmsd_pkg::ST_MUL;
      end
      wrmsd_pkg::ST_MUL: begin
        state_d = wrmsd_pkg::ST_ACC;
      end
      wrmsd_pkg::ST_ACC: begin
        if (!dim_last) begin
          state_d = wrmsd_pkg::ST_SQR;
          dim_d   = dim_q + DimW'(1);
        end else if (stat_i.last_atom) begin
          state_d = wrmsd_pkg::ST_CHECK;
        end else begin
          state_d = wrmsd_pkg::ST_IDLE;
        end
      end
      wrmsd_pkg::ST_CHECK: begin
        state_d = stat_i.special ? wrmsd_pkg::ST_DONE : wrmsd_pkg::ST_DIV;
      end
      wrmsd_pkg::ST_DIV: begin
        if (stat_i.div_last) begin
          state_d = wrmsd_pkg::ST_SQRT;
        end
      end
      wrmsd_pkg::ST_SQRT: begin
        if (stat_i.sqrt_last) begin
          state_d = wrmsd_pkg::ST_DONE;
        end
      end
      wrmsd_pkg::ST_DONE: begin
        if (stat_i.out_free) begin
          state_d = wrmsd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = wrmsd_pkg::ST_IDLE;
      end
    endcase
  end

  // Commands per state
  always_comb begin
    cmd_o      = '0;
    cmd_o.dim  = dim_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      wrmsd_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      wrmsd_pkg::ST_SQR:   cmd_o.square    = 1'b1;
      wrmsd_pkg::ST_MUL:   cmd_o.scale     = 1'b1;
      wrmsd_pkg::ST_ACC:   cmd_o.accum     = 1'b1;
      wrmsd_pkg::ST_CHECK: cmd_o.check     = 1'b1;
      wrmsd_pkg::ST_DIV:   cmd_o.div_step  = 1'b1;
      wrmsd_pkg::ST_SQRT:  cmd_o.sqrt_step = 1'b1;
      wrmsd_pkg::ST_DONE:  cmd_o.emit      = stat_i.out_free;
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  // Advance state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wrmsd_pkg::ST_IDLE;
      dim_q   <= '0;
    end else begin
      state_q <= state_d;
      dim_q   <= dim_d;
    end
  end

endmodule
`default_nettype wire

// ===== src/weighted_rmsd_accumulator.sv =====
// Each atom occupies the block while it takes the word and then squares,
// scales by mass and accumulates per dimension on a shared pair of square
// multipliers and a shared pair of mass multipliers. The last atom of a set
// adds the check, divider and square-root states and the hand-off, which
// waits while the output holds an untaken word; a zero denominator or
// an oversized rho ratio skips divider and root. Reset clears all sums, the
// sticky overflow flag, rho_mode and the output valid flag.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// weighted_rmsd_accumulator: mass-weighted RMSD / rho deviation
// Streams atoms, accumulates mass and weighted squared distances with
// saturation, and returns the deviation on the last atom of each set.
// ----------------------------------------------------------------------------
module weighted_rmsd_accumulator #(
  parameter int unsigned DIMENSIONS = wrmsd_pkg::DIMENSIONS_DEF
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   cfg_we_i,
  input  wire                   cfg_wdata_i,
  input  wire                   in_valid_i,
  output logic                  in_ready_o,
  input  wrmsd_pkg::in_word_t   in_word_i,
  output logic                  out_valid_o,
  input  wire                   out_ready_i,
  output wrmsd_pkg::out_word_t  out_word_o
);

  wrmsd_pkg::cmd_t  cmd;
  wrmsd_pkg::stat_t stat;

  // Sequencer
  wrmsd_ctrl #(
    .DIMENSIONS (DIMENSIONS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd),
    .stat_i     (stat)
  );

  // Arithmetic and result register
  wrmsd_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_word_i   (in_word_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_word_o  (out_word_o),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

endmodule
`default_nettype wire

// ===== src/wrmsd_chk.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wrmsd_chk: port-level checks of the weighted RMSD accumulator
// Watches the handshakes and result words over time; bound to the top level.
// ----------------------------------------------------------------------------
module wrmsd_chk (
  input wire                  clk_i,
  input wire                  rst_ni,
  input wire                  in_valid_i,
  input wire                  in_ready_o,
  input wire                  out_valid_o,
  input wire                  out_ready_i,
  input wrmsd_pkg::out_word_t out_word_o
);

  // Hold a stalled result word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_word_o))
    else $error("result word dropped or changed while stalled");

  // Zero denominator forces a zero deviation
  a_zero_dev: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.zero_denominator |-> out_word_o.deviation == '0)
    else $error("nonzero deviation with zero denominator");

  // An accepted word keeps the block busy for the next cycle
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken again right after an accept");

  // No result appears right after an accept
  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !$rose(out_valid_o))
    else $error("result raised right after an accept");

endmodule

bind weighted_rmsd_accumulator wrmsd_chk u_chk (.*);
`default_nettype wire
